// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the gradient sampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSGS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSGS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/msgs_pkg.sv =====
// Types and constants of the multi-stop gradient sampler.
package msgs_pkg;

    localparam int MAX_STOPS_DEF = 8;

    localparam int POS_W   = 15;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 4;
    localparam int NUM_W   = 16;
    localparam int VAL_W   = 27;
    localparam int IN_W    = 56;
    localparam int OUT_W   = 32;

    localparam logic [POS_W-1:0] POS_FULL  = 15'd25600;
    localparam logic [CNT_W-1:0] CNT_RESET = 4'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       opacity;
    } stop_entry_t;

    typedef struct packed {
        logic [7:0] opacity;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } result_t;

    localparam stop_entry_t ENTRY_ZERO = '{pos: '0, red: 8'h00, green: 8'h00,
                                           blue: 8'h00, opacity: 8'h00};
    localparam stop_entry_t ENTRY_ONE_RESET = '{pos: POS_FULL, red: 8'hFF,
                                                green: 8'hFF, blue: 8'hFF,
                                                opacity: 8'hFF};

endpackage

// ===== design/msgs_stop_mem.sv =====
// Stop table memory with one write port, one registered read port and reset valid bits.
module msgs_stop_mem #(
    parameter int DEPTH = msgs_pkg::MAX_STOPS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  msgs_pkg::stop_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output msgs_pkg::stop_entry_t rd_data
);

    msgs_pkg::stop_entry_t mem [DEPTH];
    msgs_pkg::stop_entry_t mem_q_reg;
    logic [DEPTH-1:0]      valid_reg;
    logic                  rd_valid_reg;
    logic                  rd_one_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_one_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                rd_one_reg   <= (rd_addr == AW'(1));
            end
        end
    end

    // An entry never written reads as its reset value.
    assign rd_data = rd_valid_reg ? mem_q_reg
                   : (rd_one_reg ? msgs_pkg::ENTRY_ONE_RESET : msgs_pkg::ENTRY_ZERO);

endmodule

// ===== design/msgs_lerp_unit.sv =====
// Interpolation unit: channel-serial products, then four rounding divider lanes.
module msgs_lerp_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [msgs_pkg::POS_W-1:0]   pos,
    input  msgs_pkg::stop_entry_t        left,
    input  msgs_pkg::stop_entry_t        right,
    output logic                         done,
    output msgs_pkg::result_t            result
);

    localparam int PW = msgs_pkg::POS_W;
    localparam int NW = msgs_pkg::NUM_W;
    localparam int VW = msgs_pkg::VAL_W;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    typedef enum logic [2:0] {
        L_IDLE,
        L_CLAMP,
        L_MUL,
        L_PREP,
        L_DIV,
        L_FINISH
    } lerp_state_t;

    lerp_state_t           state_reg;
    msgs_pkg::stop_entry_t left_reg;
    msgs_pkg::stop_entry_t right_reg;
    logic signed [NW-1:0]  num_reg;
    logic [PW-1:0]         den_reg;
    logic [PW-1:0]         numc_reg;
    logic [1:0]            ch_reg;
    logic [2:0]            bit_reg;
    logic signed [VW-1:0]  val_reg [4];
    logic [VW-1:0]         rem_reg [4];
    logic [7:0]            q_reg [4];
    logic [3:0]            neg_reg;
    logic [3:0]            sat_reg;
    logic                  done_reg;
    msgs_pkg::result_t     result_reg;

    logic signed [NW-1:0]  num_calc;
    logic signed [NW-1:0]  span_calc;
    logic [PW-1:0]         den_calc;
    logic [7:0]            a_ch;
    logic [7:0]            b_ch;
    logic signed [NW-1:0]  n_sel;
    logic signed [8:0]     delta;
    logic signed [24:0]    prod_d;
    logic [22:0]           prod_a;
    logic signed [VW-1:0]  val_calc;
    logic [VW-1:0]         dval [4];
    logic [VW-1:0]         sat_lim;
    logic [VW-1:0]         trial;
    logic [7:0]            lane_out [4];

    assign num_calc  = $signed({1'b0, pos}) - $signed({1'b0, left.pos});
    assign span_calc = $signed({1'b0, right.pos}) - $signed({1'b0, left.pos});
    assign den_calc  = (span_calc < 16'sd1) ? PW'(1) : span_calc[PW-1:0];

    always_comb
    begin
        case (ch_reg)
            2'd0:
            begin
                a_ch = left_reg.red;
                b_ch = right_reg.red;
            end
            2'd1:
            begin
                a_ch = left_reg.green;
                b_ch = right_reg.green;
            end
            2'd2:
            begin
                a_ch = left_reg.blue;
                b_ch = right_reg.blue;
            end
            default:
            begin
                a_ch = left_reg.opacity;
                b_ch = right_reg.opacity;
            end
        endcase
    end

    // Colour channels use the fraction clamped to 0..1, alpha the raw one.
    assign n_sel    = (ch_reg == CH_ALPHA) ? num_reg : $signed({1'b0, numc_reg});
    assign delta    = $signed({1'b0, b_ch}) - $signed({1'b0, a_ch});
    assign prod_d   = delta * n_sel;
    assign prod_a   = a_ch * den_reg;
    assign val_calc = VW'(prod_d) + $signed({4'b0, prod_a});

    assign sat_lim = {3'b0, den_reg, 9'b0};
    assign trial   = VW'({den_reg, 1'b0}) << bit_reg;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            dval[l] = {val_reg[l][VW-2:0], 1'b0} + {12'b0, den_reg};
            if (neg_reg[l])
            begin
                lane_out[l] = 8'h00;
            end
            else if (sat_reg[l])
            begin
                lane_out[l] = 8'hFF;
            end
            else
            begin
                lane_out[l] = q_reg[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            ch_reg    <= '0;
            bit_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        left_reg  <= left;
                        right_reg <= right;
                        num_reg   <= num_calc;
                        den_reg   <= den_calc;
                        state_reg <= L_CLAMP;
                    end
                end
                L_CLAMP:
                begin
                    if (num_reg <= 16'sd0)
                    begin
                        numc_reg <= '0;
                    end
                    else if (num_reg >= $signed({1'b0, den_reg}))
                    begin
                        numc_reg <= den_reg;
                    end
                    else
                    begin
                        numc_reg <= num_reg[PW-1:0];
                    end
                    ch_reg    <= '0;
                    state_reg <= L_MUL;
                end
                L_MUL:
                begin
                    val_reg[ch_reg] <= val_calc;
                    ch_reg          <= ch_reg + 2'd1;
                    if (ch_reg == CH_ALPHA)
                    begin
                        state_reg <= L_PREP;
                    end
                end
                L_PREP:
                begin
                    for (int l = 0; l < 4; l++)
                    begin
                        neg_reg[l] <= val_reg[l][VW-1];
                        rem_reg[l] <= dval[l];
                        sat_reg[l] <= (dval[l] >= sat_lim);
                        q_reg[l]   <= '0;
                    end
                    bit_reg   <= 3'd7;
                    state_reg <= L_DIV;
                end
                L_DIV:
                begin
                    for (int l = 0; l < 4; l++)
                    begin
                        if (rem_reg[l] >= trial)
                        begin
                            rem_reg[l]        <= rem_reg[l] - trial;
                            q_reg[l][bit_reg] <= 1'b1;
                        end
                    end
                    bit_reg <= bit_reg - 3'd1;
                    if (bit_reg == 3'd0)
                    begin
                        state_reg <= L_FINISH;
                    end
                end
                L_FINISH:
                begin
                    result_reg.red     <= lane_out[0];
                    result_reg.green   <= lane_out[1];
                    result_reg.blue    <= lane_out[2];
                    result_reg.opacity <= lane_out[3];
                    done_reg           <= 1'b1;
                    state_reg          <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/multi_stop_gradient_sampler_unit.sv =====
// Top level of the multi-stop gradient sampler: stream ports, stop walk and result register.
// A write transfer stores one stop and gives no result. A sample transfer reads the stop table
// one entry per cycle from entry 0 until a stop at or right of the sample position is found.
// When that is stop i, the interpolation unit runs between stops i - 1 and i (fraction clamp,
// four channel products, a rounding setup step, eight divider steps shared by four lanes and
// an output step), and the result passes through a pending register to the output register;
// the sample holds the input until its result is loaded there. A sample past the last stop in
// use returns that stop and holds the input until that stop is loaded into the output register.
// One sample is in flight at a time; a finished result may wait at the output while the next
// transfer is taken in, and a later result waits in the block until the output is free.
module multi_stop_gradient_sampler_unit #(
    parameter int MAX_STOPS = msgs_pkg::MAX_STOPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [msgs_pkg::CNT_W-1:0]    cfg_wdata,  // stop_count
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [msgs_pkg::IN_W-1:0]     s_tdata,    // stop_index, position, red, green, blue, opacity
    input  logic                          s_tuser,    // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [msgs_pkg::OUT_W-1:0]    m_tdata     // out_red, out_green, out_blue, out_opacity
);

    localparam int AW = $clog2(MAX_STOPS);
    localparam int PW = msgs_pkg::POS_W;
    localparam int IW = msgs_pkg::IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_LERP,
        S_RESULT
    } walk_state_t;

    walk_state_t                  state_reg;
    logic [msgs_pkg::CNT_W-1:0]   cnt_reg;
    logic [PW-1:0]                pos_reg;
    logic [AW-1:0]                cur_reg;
    logic [AW-1:0]                last_reg;
    msgs_pkg::stop_entry_t        prev_reg;
    msgs_pkg::result_t            pend_reg;
    msgs_pkg::result_t            out_reg;
    logic                         out_valid_reg;

    logic                         accept;
    logic [IW-1:0]                in_idx;
    msgs_pkg::stop_entry_t        in_entry;
    logic [PW-1:0]                pos_clamped;
    logic [AW-1:0]                last_calc;
    logic                         wr_en;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    msgs_pkg::stop_entry_t        rd_data;
    logic                         hit;
    logic                         at_first;
    logic                         lerp_start;
    logic                         lerp_done;
    msgs_pkg::result_t            lerp_result;
    logic                         load_out;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign in_idx           = s_tdata[2:0];
    assign in_entry.pos     = s_tdata[17:3];
    assign in_entry.red     = s_tdata[25:18];
    assign in_entry.green   = s_tdata[33:26];
    assign in_entry.blue    = s_tdata[41:34];
    assign in_entry.opacity = s_tdata[49:42];

    assign pos_clamped = (in_entry.pos > msgs_pkg::POS_FULL) ? msgs_pkg::POS_FULL
                                                             : in_entry.pos;

    always_comb
    begin
        if (cnt_reg < 4'd2)
        begin
            last_calc = AW'(1);
        end
        else if (32'(cnt_reg) > MAX_STOPS)
        begin
            last_calc = AW'(MAX_STOPS - 1);
        end
        else
        begin
            last_calc = AW'(cnt_reg - 4'd1);
        end
    end

    assign wr_en = accept && (s_tuser == msgs_pkg::CMD_WRITE) && (32'(in_idx) < MAX_STOPS);

    assign at_first   = (cur_reg == '0);
    assign hit        = (pos_reg <= rd_data.pos);
    assign lerp_start = (state_reg == S_WALK) && !at_first && hit;
    assign load_out   = (state_reg == S_RESULT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd_en   = accept && (s_tuser == msgs_pkg::CMD_SAMPLE);
            rd_addr = '0;
        end
        else
        begin
            rd_en   = (state_reg == S_WALK) && (at_first || (!hit && cur_reg != last_reg));
            rd_addr = cur_reg + AW'(1);
        end
    end

    msgs_stop_mem #(
        .DEPTH (MAX_STOPS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (AW'(in_idx)),
        .wr_data (in_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    msgs_lerp_unit u_lerp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lerp_start),
        .pos    (pos_reg),
        .left   (prev_reg),
        .right  (rd_data),
        .done   (lerp_done),
        .result (lerp_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= msgs_pkg::CNT_RESET;
            cur_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cnt_reg <= cfg_wdata;
            end
            if (load_out)
            begin
                out_reg       <= pend_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && s_tuser == msgs_pkg::CMD_SAMPLE)
                    begin
                        pos_reg   <= pos_clamped;
                        last_reg  <= last_calc;
                        cur_reg   <= '0;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    if (at_first)
                    begin
                        prev_reg <= rd_data;
                        cur_reg  <= cur_reg + AW'(1);
                    end
                    else if (hit)
                    begin
                        state_reg <= S_LERP;
                    end
                    else if (cur_reg == last_reg)
                    begin
                        pend_reg.red     <= rd_data.red;
                        pend_reg.green   <= rd_data.green;
                        pend_reg.blue    <= rd_data.blue;
                        pend_reg.opacity <= rd_data.opacity;
                        state_reg        <= S_RESULT;
                    end
                    else
                    begin
                        prev_reg <= rd_data;
                        cur_reg  <= cur_reg + AW'(1);
                    end
                end
                S_LERP:
                begin
                    if (lerp_done)
                    begin
                        pend_reg  <= lerp_result;
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== design/msgs_checker.sv =====
// Port checker for the gradient sampler, bound to the top level.
`include "assert_macros.svh"

module msgs_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       s_tuser,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [msgs_pkg::OUT_W-1:0] m_tdata
);

    `MSGS_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `MSGS_ASSERT_IMP(a_out_drop, clk, rst_n, $fell(m_tvalid), $past(m_tready), "result dropped without transfer")
    `MSGS_ASSERT_NXT(a_sample_busy, clk, rst_n, s_tvalid && s_tready && s_tuser == msgs_pkg::CMD_SAMPLE, !s_tready, "ready after sample transfer")
    `MSGS_ASSERT_NXT(a_write_ready, clk, rst_n, s_tvalid && s_tready && s_tuser == msgs_pkg::CMD_WRITE, s_tready, "busy after write transfer")

endmodule

bind multi_stop_gradient_sampler_unit msgs_checker u_msgs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
